[rtl/core/adtsfs_pkg.sv]
// Package for the ADTS frame splitter: phase encoding, result word type
// and header constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package adtsfs_pkg;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam logic [3:0]  SYNC_NIBBLE  = 4'hF;
  localparam logic [3:0]  HDR_LEN_PLAIN = 4'd7;
  localparam logic [3:0]  HDR_LEN_CRC   = 4'd9;
  localparam logic [3:0]  HC_SYNC_SEEN  = 4'd1;
  localparam logic [3:0]  HC_PROFILE    = 4'd2;
  localparam logic [3:0]  HC_CHAN       = 4'd3;
  localparam logic [3:0]  HC_LEN_MID    = 4'd4;
  localparam logic [3:0]  HC_LEN_LOW    = 4'd5;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_frame;
    logic       last_of_frame;
    logic [1:0] profile;
    logic [3:0] rate_index;
    logic [2:0] channels;
    logic       bad_length;
  } res_t;

endpackage
`default_nettype wire

[rtl/core/adts_frame_splitter_core.sv]
// ADTS frame splitter top level: input handshake, parser, output register
// with skid word. Depends on adtsfs_pkg and adtsfs_parser.
//
// Usage:
//   Input channel in_valid/in_stall/in_byte carries the ADTS byte stream,
//   one word per clock while in_stall is low. The block hunts for the
//   0xFFF sync, takes the 7 or 9 byte header, then sends each payload
//   byte on the out_ channel tagged with profile, rate index, channel
//   config and first/last marks. A frame length shorter than its header
//   gives one word with out_bad_length set. A result word is registered
//   in the output register, or in the skid word if the receiver stalls.
//   Throughput: one byte per clock while in_stall is low, set by the single
//   registered parse step and the output register.
//   Stall: if the receiver stalls, one further result goes into a skid
//   word; in_stall is high exactly while that skid word is occupied.
//   Reset (rst_n low, synchronous): the block hunts for sync, held header
//   fields clear, and both output words are empty.
`timescale 1ns / 1ps
`default_nettype none
module adts_frame_splitter_core (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [7:0]  in_byte,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_payload_byte,
  output logic       out_first_of_frame,
  output logic       out_last_of_frame,
  output logic [1:0] out_profile,
  output logic [3:0] out_rate_index,
  output logic [2:0] out_channels,
  output logic       out_bad_length
);
  import adtsfs_pkg::*;

  logic take;
  logic res_valid;
  res_t res;

  logic out_v_r, out_v_nxt;
  res_t out_d_r, out_d_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t skid_d_r, skid_d_nxt;

  assign in_stall = skid_v_r;
  assign take     = in_valid && !skid_v_r;

  adtsfs_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = res_valid;
        out_d_nxt = res;
      end
    end else if (res_valid) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_valid          = out_v_r;
  assign out_payload_byte   = out_d_r.payload_byte;
  assign out_first_of_frame = out_d_r.first_of_frame;
  assign out_last_of_frame  = out_d_r.last_of_frame;
  assign out_profile        = out_d_r.profile;
  assign out_rate_index     = out_d_r.rate_index;
  assign out_channels       = out_d_r.channels;
  assign out_bad_length     = out_d_r.bad_length;

endmodule
`default_nettype wire

[rtl/core/adtsfs_parser.sv]
// ADTS header parser and payload tagger: frame state and one result word
// per accepted payload byte or too-short frame length. Depends on adtsfs_pkg.
`timescale 1ns / 1ps
`default_nettype none
module adtsfs_parser (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 take,
  input  wire [7:0]           in_byte,
  output logic                res_valid,
  output adtsfs_pkg::res_t    res
);
  import adtsfs_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  hc_r, hc_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [3:0]  rate_r, rate_nxt;
  logic [2:0]  chan_r, chan_nxt;
  logic        crc_r, crc_nxt;
  logic [12:0] flen_r, flen_nxt;
  logic [12:0] left_r, left_nxt;
  logic        firstp_r, firstp_nxt;

  logic [3:0]  hc_inc;
  logic [3:0]  hlen;
  logic        hdr_done;
  logic        short_len;
  logic        empty_len;
  logic        left_zero;
  logic        left_one;
  logic [12:0] left_dec;

  assign hc_inc    = hc_r + 4'd1;
  assign hlen      = crc_r ? HDR_LEN_CRC : HDR_LEN_PLAIN;
  assign hdr_done  = (hc_inc >= hlen);
  assign short_len = (flen_nxt < {9'd0, hlen});
  assign empty_len = (flen_nxt == {9'd0, hlen});
  assign left_zero = (left_r == 13'd0);
  assign left_one  = (left_r == 13'd1);
  assign left_dec  = left_r - 13'd1;

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    hc_nxt     = hc_r;
    prof_nxt   = prof_r;
    rate_nxt   = rate_r;
    chan_nxt   = chan_r;
    crc_nxt    = crc_r;
    flen_nxt   = flen_r;
    left_nxt   = left_r;
    firstp_nxt = firstp_r;
    case (phase_r)
      PH_HEADER: begin
        case (hc_r)
          HC_PROFILE: begin
            prof_nxt = in_byte[7:6];
            rate_nxt = in_byte[5:2];
            chan_nxt = {in_byte[0], 2'b00};
          end
          HC_CHAN: begin
            chan_nxt = {chan_r[2], in_byte[7:6]};
            flen_nxt = {in_byte[1:0], 11'd0};
          end
          HC_LEN_MID: flen_nxt = {flen_r[12:11], in_byte, 3'd0};
          HC_LEN_LOW: flen_nxt = {flen_r[12:3], in_byte[7:5]};
          default: ;
        endcase
        hc_nxt = hc_inc;
        if (hdr_done) begin
          hc_nxt = 4'd0;
          if (short_len || empty_len) begin
            phase_nxt = PH_HUNT;
          end else begin
            left_nxt   = flen_nxt - {9'd0, hlen};
            firstp_nxt = 1'b1;
            phase_nxt  = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        if (left_zero) begin
          phase_nxt = PH_HUNT;
          hc_nxt    = (in_byte == SYNC_BYTE) ? HC_SYNC_SEEN : 4'd0;
        end else begin
          firstp_nxt = 1'b0;
          left_nxt   = left_dec;
          if (left_one) begin
            phase_nxt = PH_HUNT;
            hc_nxt    = 4'd0;
          end
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        if (hc_r == HC_SYNC_SEEN && in_byte[7:4] == SYNC_NIBBLE) begin
          crc_nxt   = ~in_byte[0];
          hc_nxt    = HC_PROFILE;
          phase_nxt = PH_HEADER;
        end else begin
          hc_nxt = (in_byte == SYNC_BYTE) ? HC_SYNC_SEEN : 4'd0;
        end
      end
    endcase
  end

  // result word
  always_comb begin
    res_valid          = 1'b0;
    res.payload_byte   = in_byte;
    res.first_of_frame = firstp_r;
    res.last_of_frame  = left_one;
    res.profile        = prof_r;
    res.rate_index     = rate_r;
    res.channels       = chan_r;
    res.bad_length     = 1'b0;
    case (phase_r)
      PH_HEADER: begin
        if (hdr_done && short_len) begin
          res_valid          = take;
          res.payload_byte   = 8'd0;
          res.first_of_frame = 1'b0;
          res.last_of_frame  = 1'b1;
          res.bad_length     = 1'b1;
        end
      end
      PH_PAYLOAD: res_valid = take && !left_zero;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      hc_r     <= 4'd0;
      prof_r   <= 2'd0;
      rate_r   <= 4'd0;
      chan_r   <= 3'd0;
      crc_r    <= 1'b0;
      flen_r   <= 13'd0;
      left_r   <= 13'd0;
      firstp_r <= 1'b0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      hc_r     <= hc_nxt;
      prof_r   <= prof_nxt;
      rate_r   <= rate_nxt;
      chan_r   <= chan_nxt;
      crc_r    <= crc_nxt;
      flen_r   <= flen_nxt;
      left_r   <= left_nxt;
      firstp_r <= firstp_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/core/adtsfs_checker.sv]
// Port-level checks for adts_frame_splitter_core, bound to the top level.
// Depends on adts_frame_splitter_core ports only.
`timescale 1ns / 1ps
`default_nettype none
module adtsfs_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_payload_byte,
  input wire       out_first_of_frame,
  input wire       out_last_of_frame,
  input wire [1:0] out_profile,
  input wire [3:0] out_rate_index,
  input wire [2:0] out_channels,
  input wire       out_bad_length
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_first_of_frame) && $stable(out_last_of_frame)
      && $stable(out_profile) && $stable(out_rate_index)
      && $stable(out_channels) && $stable(out_bad_length))
    else $error("stalled output word changed");

  a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall && in_valid))
    else $error("input stall without output stall");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_length |-> out_last_of_frame && !out_first_of_frame
      && out_payload_byte == 8'd0)
    else $error("malformed length error word");

endmodule

bind adts_frame_splitter_core adtsfs_checker u_adtsfs_checker (.*);
`default_nettype wire
